// ===== hw/rtl/rbsi_pkg.sv =====
// Shared constants, types and register codes for the ray/box slab test.
// No dependencies; imported by rbsi_div and ray_box_slab_intersect.
`default_nettype none
package rbsi_pkg;

	localparam int Q_W       = 32;               // Q16.16 word
	localparam int FRAC_W    = 16;               // fraction bits
	localparam int NUM_W     = Q_W + FRAC_W;     // scaled dividend magnitude
	localparam int DIV_STEPS = Q_W;              // quotient bits, one per stage
	localparam int DIV_LAT   = DIV_STEPS + 2;    // entry + steps + saturate
	localparam int AXES      = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic signed [Q_W:0]   diff_t;   // bound - origin, exact

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

	// per-item flags that ride alongside the dividers
	typedef struct packed {
		logic [AXES-1:0] par;    // axis direction is zero
		logic            ok;     // no parallel axis missed
		q_t              len;
	} side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rbsi_div.sv =====
// Pipelined signed Q16.16 divider, one quotient bit per stage, saturating.
// Depends on rbsi_pkg. All stages advance only while en is high.
`default_nettype none
module rbsi_div (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [rbsi_pkg::NUM_W-1:0]   num_mag,
	input  wire logic [rbsi_pkg::Q_W-1:0]     den_mag,
	input  wire logic                         neg,
	output rbsi_pkg::q_t                      quot
);
	import rbsi_pkg::*;

	logic [Q_W:0]   rem_s  [DIV_STEPS+1];
	logic [Q_W-1:0] low_s  [DIV_STEPS+1];
	logic [Q_W-1:0] den_s  [DIV_STEPS+1];
	logic           neg_s  [DIV_STEPS+1];
	logic           ovf_s  [DIV_STEPS+1];
	q_t             quot_q;

	// quotient >= 2^32 exactly when the top dividend bits reach the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {{(Q_W+1-FRAC_W){1'b0}}, num_mag[NUM_W-1:Q_W]};
			low_s[0] <= num_mag[Q_W-1:0];
			den_s[0] <= den_mag;
			neg_s[0] <= neg;
			ovf_s[0] <= ({{(Q_W-FRAC_W){1'b0}}, num_mag[NUM_W-1:Q_W]} >= den_mag);
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [Q_W:0] trial;
		logic         ge;
		assign trial = {rem_s[k][Q_W-1:0], low_s[k][Q_W-1]};
		assign ge    = (trial >= {1'b0, den_s[k]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (trial - {1'b0, den_s[k]}) : trial;
				low_s[k+1] <= {low_s[k][Q_W-2:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic [Q_W-1:0] qmag;
	assign qmag = low_s[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[DIV_STEPS]) begin
				quot_q <= neg_s[DIV_STEPS] ? Q_MIN : Q_MAX;
			end else if (neg_s[DIV_STEPS]) begin
				quot_q <= (qmag > Q_MIN) ? Q_MIN : q_t'(-qmag);
			end else begin
				quot_q <= (qmag > Q_MAX) ? Q_MAX : q_t'(qmag);
			end
		end
	end

	assign quot = quot_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// Ray versus axis-aligned box, three-slab test, signed Q16.16.
// Depends on rbsi_pkg and rbsi_div.
//
// Streams one ray per cycle: a new transfer is taken every clock while the
// result side keeps up, and every ray yields exactly one result. Six dividers
// (two per axis) each resolve one quotient bit per pipeline stage. The whole
// pipe moves on one enable, so a stall at the output freezes every stage and
// nothing is lost or repeated. Box bounds are written through the cfg channel
// (index 0..5 = min x,y,z, max x,y,z); write them only while no ray is in
// flight. An axis whose direction is exactly zero does not narrow the limits,
// and misses outright if the origin lies outside that slab. Distances saturate
// to the Q16.16 extremes; a miss returns hit 0 with distance 0.
`default_nettype none
module ray_box_slab_intersect (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rbsi_pkg::Q_W-1:0]      cfg_data,
	// ray in
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire rbsi_pkg::q_t                  origin_x,
	input  wire rbsi_pkg::q_t                  origin_y,
	input  wire rbsi_pkg::q_t                  origin_z,
	input  wire rbsi_pkg::q_t                  direction_x,
	input  wire rbsi_pkg::q_t                  direction_y,
	input  wire rbsi_pkg::q_t                  direction_z,
	input  wire rbsi_pkg::q_t                  max_length,
	// result out
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic                          hit,
	output      rbsi_pkg::q_t                  hit_distance
);
	import rbsi_pkg::*;

	// box bounds
	q_t bmin_q [AXES];
	q_t bmax_q [AXES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				bmin_q[a] <= '0;
				bmax_q[a] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_X: bmin_q[0] <= cfg_data;
				REG_MIN_Y: bmin_q[1] <= cfg_data;
				REG_MIN_Z: bmin_q[2] <= cfg_data;
				REG_MAX_X: bmax_q[0] <= cfg_data;
				REG_MAX_Y: bmax_q[1] <= cfg_data;
				REG_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// one enable for the whole pipe; output register frees on transfer
	logic pipe_en;
	logic v_s4;
	assign pipe_en  = !v_s4 || out_ready;
	assign in_ready = pipe_en;

	q_t org [AXES];
	q_t dir [AXES];
	assign org = '{origin_x, origin_y, origin_z};
	assign dir = '{direction_x, direction_y, direction_z};

	// ---- s1: slab differences, parallel-axis check
	logic  v_s1;
	diff_t dlo_s1 [AXES];
	diff_t dhi_s1 [AXES];
	q_t    dir_s1 [AXES];
	side_t side_s1;
	logic  par_miss;

	// a parallel axis with the origin outside its slab misses outright
	always_comb begin
		par_miss = 1'b0;
		for (int a = 0; a < AXES; a++)
			if (dir[a] == '0 && (org[a] < bmin_q[a] || org[a] > bmax_q[a]))
				par_miss = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (pipe_en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s1.ok  <= !par_miss;
			side_s1.len <= max_length;
			for (int a = 0; a < AXES; a++) begin
				dlo_s1[a] <= diff_t'(bmin_q[a]) - diff_t'(org[a]);
				dhi_s1[a] <= diff_t'(bmax_q[a]) - diff_t'(org[a]);
				dir_s1[a] <= dir[a];
				side_s1.par[a] <= (dir[a] == '0);
			end
		end
	end

	// ---- dividers: t = (diff << 16) / dir
	q_t ta_d [AXES];
	q_t tb_d [AXES];

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic [Q_W-1:0] lo_mag, hi_mag, dir_mag;
		diff_t          lo_abs, hi_abs;
		assign lo_abs  = dlo_s1[a][Q_W] ? -dlo_s1[a] : dlo_s1[a];
		assign hi_abs  = dhi_s1[a][Q_W] ? -dhi_s1[a] : dhi_s1[a];
		assign lo_mag  = lo_abs[Q_W-1:0];
		assign hi_mag  = hi_abs[Q_W-1:0];
		assign dir_mag = dir_s1[a][Q_W-1] ? (Q_W)'(-dir_s1[a]) : dir_s1[a];

		rbsi_div u_div_lo (
			.clk     (clk),
			.en      (pipe_en),
			.num_mag ({lo_mag, {FRAC_W{1'b0}}}),
			.den_mag (dir_mag),
			.neg     (dlo_s1[a][Q_W] ^ dir_s1[a][Q_W-1]),
			.quot    (ta_d[a])
		);
		rbsi_div u_div_hi (
			.clk     (clk),
			.en      (pipe_en),
			.num_mag ({hi_mag, {FRAC_W{1'b0}}}),
			.den_mag (dir_mag),
			.neg     (dhi_s1[a][Q_W] ^ dir_s1[a][Q_W-1]),
			.quot    (tb_d[a])
		);
	end

	// sideband line matching divider latency
	logic  v_line    [DIV_LAT];
	side_t side_line [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) v_line[i] <= 1'b0;
		end else if (pipe_en) begin
			v_line[0] <= v_s1;
			for (int i = 1; i < DIV_LAT; i++) v_line[i] <= v_line[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_line[0] <= side_s1;
			for (int i = 1; i < DIV_LAT; i++) side_line[i] <= side_line[i-1];
		end
	end

	logic  v_d;
	side_t side_d;
	assign v_d    = v_line[DIV_LAT-1];
	assign side_d = side_line[DIV_LAT-1];

	// ---- s2: order each axis pair; parallel axes do not narrow
	logic  v_s2;
	q_t    near_s2 [AXES];
	q_t    far_s2  [AXES];
	side_t side_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s2 <= side_d;
			for (int a = 0; a < AXES; a++) begin
				if (side_d.par[a]) begin
					near_s2[a] <= Q_MIN;
					far_s2[a]  <= Q_MAX;
				end else if (ta_d[a] > tb_d[a]) begin
					near_s2[a] <= tb_d[a];
					far_s2[a]  <= ta_d[a];
				end else begin
					near_s2[a] <= ta_d[a];
					far_s2[a]  <= tb_d[a];
				end
			end
		end
	end

	// ---- s3: near = max of entries, far = min of exits
	logic  v_s3;
	q_t    lo_s3, hi_s3;
	side_t side_s3;
	q_t    lo01, hi01;

	assign lo01 = (near_s2[1] > near_s2[0]) ? near_s2[1] : near_s2[0];
	assign hi01 = (far_s2[1] < far_s2[0]) ? far_s2[1] : far_s2[0];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s3 <= side_s2;
			lo_s3   <= (near_s2[2] > lo01) ? near_s2[2] : lo01;
			hi_s3   <= (far_s2[2] < hi01) ? far_s2[2] : hi01;
		end
	end

	// ---- s4: pick distance, final checks, output register
	q_t   pick;
	logic ok;
	logic hit_s4;
	q_t   dist_s4;

	assign pick = (lo_s3 > 0) ? lo_s3 : hi_s3;
	assign ok   = side_s3.ok && !(lo_s3 > hi_s3) && !hi_s3[Q_W-1]
		&& !(pick > side_s3.len);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			hit_s4  <= ok;
			dist_s4 <= ok ? pick : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= v_d;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid    = v_s4;
	assign hit          = hit_s4;
	assign hit_distance = dist_s4;

	// a miss always reports distance zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !hit_s4 |-> dist_s4 == '0)
		else $error("miss with nonzero distance");

	// a hit never lies behind the origin
	a_hit_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && hit_s4 |-> !dist_s4[Q_W-1])
		else $error("hit with negative distance");

	// a stall holds the inner pipe
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> v_s3 == $past(v_s3) && v_s2 == $past(v_s2))
		else $error("pipe moved during stall");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for ray_box_slab_intersect: directed and random rays,
// box reconfiguration between phases, random idling and a long output stall.
// Depends on rbsi_pkg and the ray_box_slab_intersect RTL.
`default_nettype none
module tb_top;
	import rbsi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = DIV_LAT + 4;
	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [Q_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	q_t origin_x = '0, origin_y = '0, origin_z = '0;
	q_t direction_x = '0, direction_y = '0, direction_z = '0;
	q_t max_length = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	q_t hit_distance;

	typedef struct {
		logic hit;
		q_t distance;
	} hit_result_t;

	typedef struct {
		q_t org[3];
		q_t dir[3];
		q_t len;
	} ray_t;

	// box copy used by the predictor
	q_t box_lo[3];
	q_t box_hi[3];
	hit_result_t expected_hits[$];
	int errors = 0;
	int idle_cycles = 0;
	int rx_gap = 0;
	bit hold_output = 1'b0;   // forces out_ready low for the long stall
	bit random_ready = 1'b1;

	ray_box_slab_intersect dut (.*);

	always #2 clk = ~clk;

	// --- predictor ---
	function automatic longint clamp_q(longint v);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		return v;
	endfunction

	function automatic hit_result_t trace_ray(ray_t r);
		hit_result_t res;
		longint near_t, far_t, ta, tb, tmp, pick, o, d, lo, hi;
		bit ok;
		near_t = longint'(Q_MIN);
		far_t = longint'(Q_MAX);
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			o = longint'(r.org[a]);
			d = longint'(r.dir[a]);
			lo = longint'(box_lo[a]);
			hi = longint'(box_hi[a]);
			if (d == 0) begin
				// parallel axis: only a containment test
				if (o < lo || o > hi) ok = 1'b0;
			end else begin
				// SV division truncates toward zero like C
				ta = clamp_q(((lo - o) * 65536) / d);
				tb = clamp_q(((hi - o) * 65536) / d);
				if (ta > tb) begin
					tmp = ta; ta = tb; tb = tmp;
				end
				if (ta > near_t) near_t = ta;
				if (tb < far_t) far_t = tb;
			end
		end
		if (near_t > far_t) ok = 1'b0;
		if (far_t < 0) ok = 1'b0;
		pick = (near_t > 0) ? near_t : far_t;
		if (pick > longint'(r.len)) ok = 1'b0;
		res.hit = ok;
		res.distance = ok ? q_t'(pick) : '0;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// --- drivers ---
	// cfg_valid stays high across back-to-back writes; set_box drops it
	task automatic write_box(cfg_reg_t idx, q_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MIN_X: box_lo[0] = value;
			REG_MIN_Y: box_lo[1] = value;
			REG_MIN_Z: box_lo[2] = value;
			REG_MAX_X: box_hi[0] = value;
			REG_MAX_Y: box_hi[1] = value;
			REG_MAX_Z: box_hi[2] = value;
			default: ;
		endcase
	endtask

	task automatic set_box(q_t lx, q_t ly, q_t lz, q_t hx, q_t hy, q_t hz);
		drain();
		write_box(REG_MIN_X, lx);
		write_box(REG_MIN_Y, ly);
		write_box(REG_MIN_Z, lz);
		write_box(REG_MAX_X, hx);
		write_box(REG_MAX_Y, hy);
		write_box(REG_MAX_Z, hz);
		cfg_valid <= 1'b0;
	endtask

	// send one ray; optional randomly drawn idle gap before it
	task automatic send_ray(ray_t r, bit gaps);
		int gap;
		gap = gaps ? int'($urandom_range(0, 5)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			wait_cycles(gap);
		end
		in_valid <= 1'b1;
		origin_x <= r.org[0]; origin_y <= r.org[1]; origin_z <= r.org[2];
		direction_x <= r.dir[0]; direction_y <= r.dir[1]; direction_z <= r.dir[2];
		max_length <= r.len;
		do @(posedge clk); while (!in_ready);
		expected_hits.push_back(trace_ray(r));
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every expected result, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		wait_cycles(LATENCY + 4);
	endtask

	function automatic q_t rand_q();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return q_t'(0);
			3: return q_t'($urandom);
			default: return q_t'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic ray_t make_ray(q_t ox, q_t oy, q_t oz, q_t dx, q_t dy, q_t dz,
		q_t len);
		ray_t r;
		r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
		r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
		r.len = len;
		return r;
	endfunction

	// ray aimed roughly at the unit-ish box, random content
	function automatic ray_t aimed_ray();
		ray_t r;
		for (int a = 0; a < 3; a++) begin
			r.org[a] = q_t'($signed($urandom_range(0, 30 << 16)) - (15 << 16));
			r.dir[a] = ($urandom_range(0, 7) == 0) ? q_t'(0) :
				q_t'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
		end
		r.len = ($urandom_range(0, 2) == 0) ? Q_MAX : q_t'($urandom_range(0, 60 << 16));
		return r;
	endfunction

	// --- result checker ---
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected result", hit, 0);
			end else begin
				hit_result_t want;
				want = expected_hits.pop_front();
				if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
				if (hit_distance !== want.distance)
					report_mismatch("hit_distance", hit_distance, want.distance);
			end
		end
	end

	// receiver: random idle gap drawn per result, always ready when random_ready is low, or hold off when asked
	always @(posedge clk) begin
		if (out_valid && out_ready) rx_gap = $urandom_range(0, 5);
		else if (rx_gap > 0) rx_gap = rx_gap - 1;
		if (hold_output) out_ready <= 1'b0;
		else if (!random_ready) out_ready <= 1'b1;
		else out_ready <= (rx_gap == 0);
	end

	// watchdog: cycles with no transfer anywhere and no held output
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
			|| hold_output)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// --- tests ---
	task automatic test_directed();
		set_box(-(1 << 16), -(1 << 16), -(1 << 16), 1 << 16, 1 << 16, 1 << 16);
		send_ray(make_ray(-(5 << 16), 0, 0, 1 << 16, 0, 0, Q_MAX), 0); // frontal hit
		send_ray(make_ray(0, 0, 0, 1 << 16, 1 << 16, 1 << 16, Q_MAX), 0); // from inside
		send_ray(make_ray(0, 0, 0, 0, 0, 0, Q_MAX), 0);       // all parallel, inside
		send_ray(make_ray(0, 0, 0, 0, 0, 0, Q_MAX - 1), 0);   // same, limited length
		send_ray(make_ray(5 << 16, 0, 0, 0, 1 << 16, 0, Q_MAX), 0); // parallel outside
		send_ray(make_ray(-(5 << 16), 0, 0, -(1 << 16), 0, 0, Q_MAX), 0); // behind
		send_ray(make_ray(-(5 << 16), 0, 0, 1 << 16, 0, 0, 3 << 16), 0); // too short
		send_ray(make_ray(-(5 << 16), 0, 0, 1 << 16, 0, 0, 4 << 16), 0); // exact length
		send_ray(make_ray(-(5 << 16), 0, 0, 1 << 16, 0, 0, Q_MIN), 0); // negative length
		send_ray(make_ray(Q_MIN, Q_MIN, Q_MIN, 1, 1, 1, Q_MAX), 0); // saturating
		send_ray(make_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX), 0);
		send_ray(make_ray(Q_MIN, 0, Q_MAX, Q_MAX, -1, Q_MIN, Q_MAX), 0);
		send_ray(make_ray(-(5 << 16), -(5 << 16), 0, 1 << 16, -(1 << 16), 0, Q_MAX), 0);
		send_ray(make_ray(1 << 16, 1 << 16, 1 << 16, 0, 0, 0, Q_MAX), 0); // on the edge
		end_burst();
		// inverted box
		set_box(1 << 16, 1 << 16, 1 << 16, -(1 << 16), -(1 << 16), -(1 << 16));
		send_ray(make_ray(-(5 << 16), 0, 0, 1 << 16, 1 << 16, 1 << 16, Q_MAX), 0);
		send_ray(make_ray(0, 0, 0, 0, 1 << 16, 1 << 16, Q_MAX), 0);
		send_ray(make_ray(0, 0, 0, -(1 << 16), 1 << 16, 1, Q_MAX), 0);
		end_burst();
		// extreme box
		set_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
		send_ray(make_ray(0, 0, 0, 0, 0, 0, Q_MAX), 0);
		send_ray(make_ray(Q_MIN, Q_MAX, 0, 1, -1, Q_MAX, Q_MAX), 0);
		send_ray(make_ray(Q_MAX, Q_MIN, 0, Q_MIN, 1, 1 << 16, 7 << 16), 0);
		end_burst();
	endtask

	task automatic test_random(int count);
		ray_t r;
		for (int i = 0; i < count; i++) begin
			if (i % 75 == 0) begin
				end_burst();
				if ($urandom_range(0, 1))
					set_box(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
				else
					set_box(-q_t'($urandom_range(0, 8 << 16)), -q_t'($urandom_range(0, 8 << 16)),
						-q_t'($urandom_range(0, 8 << 16)), q_t'($urandom_range(0, 8 << 16)),
						q_t'($urandom_range(0, 8 << 16)), q_t'($urandom_range(0, 8 << 16)));
			end
			if ($urandom_range(0, 3) == 0) begin
				for (int a = 0; a < 3; a++) begin
					r.org[a] = rand_q();
					r.dir[a] = rand_q();
				end
				r.len = rand_q();
			end else begin
				r = aimed_ray();
			end
			// no idling for a stretch every so often
			send_ray(r, (i / 40) % 3 != 0);
		end
		end_burst();
	endtask

	// output held off for a long stretch while rays keep coming
	task automatic test_backpressure();
		fork
			begin
				hold_output = 1'b1;
				wait_cycles(200);
				hold_output = 1'b0;
			end
			for (int i = 0; i < 60; i++) send_ray(aimed_ray(), 0);
		join
		end_burst();
		// sender pauses until everything is back, then one more ray
		while (expected_hits.size() != 0) @(posedge clk);
		random_ready = 1'b0;
		send_ray(aimed_ray(), 0);
		end_burst();
		random_ready = 1'b1;
	endtask

	initial begin
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = '0;
			box_hi[a] = '0;
		end
		wait_cycles(6);
		arst_n <= 1'b1;
		wait_cycles(2);
		test_directed();
		test_backpressure();
		test_random(380);
		drain();
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
